// ===== design/tss_pkg.sv =====
package tss_pkg;

   // Table geometry
   localparam int unsigned TABLE_DEPTH = 1024;
   localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
   localparam int unsigned CNT_W       = IDX_W + 1;
   localparam int unsigned ENTRY_W     = 32;
   localparam int unsigned CFG_W       = 11;

   // Divide-by-3 unit: quotient = (x * DIV_RECIP) >> DIV_SHIFT, exact for x < 2**DIV_W
   localparam int unsigned DIV_W       = IDX_W + 2;
   localparam int unsigned DIV_SHIFT   = DIV_W + 1;
   localparam int unsigned DIV_RECIP   = (2 ** DIV_SHIFT) / 3 + 1;
   localparam int unsigned PROD_W      = 2 * DIV_W;

   // Command codes
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PROBE_L,
      S_PROBE_R,
      S_DECIDE,
      S_DONE
   } state_type;

endpackage

// ===== design/tss_req_if.sv =====
interface tss_req_if import tss_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      command;
   logic [IDX_W-1:0]          entry_index;
   logic signed [ENTRY_W-1:0] entry_value;
   logic signed [ENTRY_W-1:0] search_key;

   modport source (output valid, command, entry_index, entry_value, search_key,
                   input ready);
   modport sink   (input valid, command, entry_index, entry_value, search_key,
                   output ready);
endinterface

// ===== design/tss_rsp_if.sv =====
interface tss_rsp_if import tss_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             found;
   logic [IDX_W-1:0] position;

   modport source (output valid, found, position, input ready);
   modport sink   (input valid, found, position, output ready);
endinterface

// ===== design/tss_csr_if.sv =====
interface tss_csr_if import tss_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== design/tss_ram.sv =====
module tss_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ternary_search_sorted_table.sv =====
// Channel   Dir  Beat contents
// req_chan  in   command, entry_index, entry_value, search_key
// rsp_chan  out  found, position (one beat per search, none per write)
// csr_chan  in   entries_in_use write data
//
// A write beat stores one entry in the cycle it is accepted. A search runs in
// ternary rounds (left probe read, right probe read, range update), one step at
// a time, as set by the single read port of the table RAM and the one shared
// divide-by-3 multiplier.
// Reset is synchronous and clears the control state, the entry count and the output valid flag only.
// A finished result waits in the output register; the next beat is taken
// meanwhile, and a second result holds in S_DONE until the first is taken.
module ternary_search_sorted_table import tss_pkg::*; (
   input logic          clock,
   input logic          reset,
   tss_req_if.sink      req_chan,
   tss_rsp_if.source    rsp_chan,
   tss_csr_if.sink      csr_chan
);

   state_type                 state_ff, state_in;
   logic [CFG_W-1:0]          count_ff;
   logic [CNT_W-1:0]          lo_ff, lo_in;
   logic [CNT_W-1:0]          hi_ff, hi_in;
   logic [CNT_W-1:0]          limit_ff, limit_in;
   logic signed [ENTRY_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0]          lm_ff, lm_in;
   logic [IDX_W-1:0]          rm_ff, rm_in;
   logic                      lt_l_ff, lt_l_in;
   logic                      res_found_ff, res_found_in;
   logic [IDX_W-1:0]          res_pos_ff, res_pos_in;
   logic                      rsp_valid_ff;
   logic                      rsp_found_ff;
   logic [IDX_W-1:0]          rsp_pos_ff;

   logic                      req_beat;
   logic                      load_rsp;
   logic                      rd_en;
   logic                      div_right;
   logic [DIV_W-1:0]          div_x;
   logic [PROD_W-1:0]         div_prod;
   logic [IDX_W-1:0]          div_q;
   logic [ENTRY_W-1:0]        rd_data;
   logic signed [ENTRY_W-1:0] rd_val;
   logic [CNT_W-1:0]          limit_now;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_beat       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // Clamp the configured count to the table depth
   assign limit_now = (count_ff > CFG_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                      : CNT_W'(count_ff);

   // Shared divide-by-3 unit: (2*lo+hi)/3 for the left probe, (lo+2*hi)/3 for the right
   always_comb begin
      if (div_right) begin
         div_x = DIV_W'(lo_ff) + DIV_W'({hi_ff, 1'b0});
      end else begin
         div_x = DIV_W'({lo_ff, 1'b0}) + DIV_W'(hi_ff);
      end
   end
   assign div_prod = PROD_W'(div_x) * PROD_W'(DIV_RECIP);
   assign div_q    = div_prod[DIV_SHIFT +: IDX_W];

   tss_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (req_beat && (req_chan.command == CMD_WRITE)),
      .wr_addr (req_chan.entry_index),
      .wr_data (req_chan.entry_value),
      .rd_en   (rd_en),
      .rd_addr (div_q),
      .rd_data (rd_data)
   );

   assign rd_val = $signed(rd_data);

   // State register and search datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      limit_ff     <= limit_in;
      key_ff       <= key_in;
      lm_ff        <= lm_in;
      rm_ff        <= rm_in;
      lt_l_ff      <= lt_l_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
   end

   // Next state and sequencer outputs
   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      limit_in     = limit_ff;
      key_in       = key_ff;
      lm_in        = lm_ff;
      rm_in        = rm_ff;
      lt_l_in      = lt_l_ff;
      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;
      rd_en        = 1'b0;
      div_right    = 1'b0;
      load_rsp     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_beat && (req_chan.command == CMD_SEARCH)) begin
               key_in   = req_chan.search_key;
               lo_in    = '0;
               hi_in    = limit_now;
               limit_in = limit_now;
               if (limit_now == '0) begin
                  res_found_in = 1'b0;
                  res_pos_in   = '0;
                  state_in     = S_DONE;
               end else begin
                  state_in = S_PROBE_L;
               end
            end
         end
         S_PROBE_L: begin
            // Read the left third point
            rd_en    = 1'b1;
            lm_in    = div_q;
            state_in = S_PROBE_R;
         end
         S_PROBE_R: begin
            // Read the right third point, check the left one
            div_right = 1'b1;
            rd_en     = 1'b1;
            rm_in     = div_q;
            lt_l_in   = key_ff < rd_val;
            if (rd_val == key_ff) begin
               res_found_in = 1'b1;
               res_pos_in   = lm_ff;
               state_in     = S_DONE;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            // Check the right point, then narrow the range
            if (rd_val == key_ff) begin
               res_found_in = 1'b1;
               res_pos_in   = rm_ff;
               state_in     = S_DONE;
            end else begin
               priority if (lt_l_ff) begin
                  hi_in = CNT_W'(lm_ff);
               end else if (rd_val < key_ff) begin
                  lo_in = CNT_W'(rm_ff) + CNT_W'(1);
               end else begin
                  lo_in = CNT_W'(lm_ff) + CNT_W'(1);
                  hi_in = CNT_W'(rm_ff);
               end
               if (lo_in < hi_in) begin
                  state_in = S_PROBE_L;
               end else begin
                  res_found_in = 1'b0;
                  res_pos_in   = '0;
                  state_in     = S_DONE;
               end
            end
         end
         S_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Entry count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_chan.valid) begin
         count_ff <= csr_chan.data;
      end
   end

   // Output register: load a finished result, drop it once the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_rsp) begin
         rsp_found_ff <= res_found_ff;
         rsp_pos_ff   <= res_pos_ff;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.found    = rsp_found_ff;
   assign rsp_chan.position = rsp_pos_ff;

   // A round starts only on a non-empty range
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE_L) |-> (lo_ff < hi_ff))
      else $error("probe started on an empty range");

   // Every range update shrinks the range or ends the search
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && rd_val != key_ff) |=>
         (lo_ff >= hi_ff) || ((hi_ff - lo_ff) < $past(hi_ff - lo_ff)))
      else $error("search range did not shrink");

   // A found position lies inside the searched range
   assert property (@(posedge clock) disable iff (reset)
      (load_rsp && res_found_ff) |-> (CNT_W'(res_pos_ff) < limit_ff))
      else $error("found position beyond entry count");

   // A miss reports position zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_pos_ff == '0))
      else $error("miss with nonzero position");

   // Search results appear only after the sequencer finishes
   assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (state_ff == S_DONE) ##1 (state_ff == S_IDLE && rsp_valid_ff))
      else $error("result load outside done state");

endmodule

// ===== tb/ternary_search_sorted_table_test.sv =====
module ternary_search_sorted_table_test import tss_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic signed [ENTRY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [ENTRY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned PHASES        = 10;
   localparam int unsigned PHASE_BEATS   = 72;

   typedef struct packed {
      logic                      command;
      logic [IDX_W-1:0]          entry_index;
      logic signed [ENTRY_W-1:0] entry_value;
      logic signed [ENTRY_W-1:0] search_key;
   } table_op_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] position;
   } lookup_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // locally held copies of every block input, known from time zero
   logic             req_valid = 1'b0;
   table_op_type     req_beat  = '0;
   logic             rsp_ready = 1'b0;
   logic             csr_valid = 1'b0;
   logic [CFG_W-1:0] csr_data  = '0;

   tss_req_if req_chan ();
   tss_rsp_if rsp_chan ();
   tss_csr_if csr_chan ();

   assign req_chan.valid       = req_valid;
   assign req_chan.command     = req_beat.command;
   assign req_chan.entry_index = req_beat.entry_index;
   assign req_chan.entry_value = req_beat.entry_value;
   assign req_chan.search_key  = req_beat.search_key;
   assign rsp_chan.ready       = rsp_ready;
   assign csr_chan.valid       = csr_valid;
   assign csr_chan.data        = csr_data;

   ternary_search_sorted_table dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #2 clock = ~clock;

   // stimulus plan: the table as it will look once every planned beat lands
   logic signed [ENTRY_W-1:0] plan_entries [TABLE_DEPTH];
   table_op_type              pending_beats [$];
   int unsigned               beats_planned  = 0;
   int unsigned               beats_accepted = 0;

   // predictor state: table and count as the block holds them
   logic signed [ENTRY_W-1:0] table_copy [TABLE_DEPTH];
   logic [CFG_W-1:0]          entry_count = '0;
   lookup_result_type         expected_results [$];

   int unsigned req_gap   = 0;
   int unsigned rsp_stall = 0;
   logic        rsp_hold  = 1'b0;
   bit          idle_on   = 1'b1;
   int          phase_no  = -1;
   int unsigned fail_count = 0;
   lookup_result_type want;

   function automatic int unsigned idle_length();
      int unsigned r;
      if (!idle_on) return 0;
      r = $urandom_range(99, 0);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(15, 4);
      return $urandom_range(80, 30);
   endfunction

   // ternary search over [0, count), left third probed before right third
   function automatic lookup_result_type ternary_lookup(logic signed [ENTRY_W-1:0] key);
      int unsigned       lo, hi, lm, rm;
      lookup_result_type res;
      res = '0;
      lo  = 0;
      hi  = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : entry_count;
      while (lo < hi) begin
         lm = (2 * lo + hi) / 3;
         if (table_copy[lm] == key) begin
            res.found    = 1'b1;
            res.position = lm[IDX_W-1:0];
            return res;
         end
         rm = (lo + 2 * hi) / 3;
         if (table_copy[rm] == key) begin
            res.found    = 1'b1;
            res.position = rm[IDX_W-1:0];
            return res;
         end
         if (key < table_copy[lm]) begin
            hi = lm;
         end else if (table_copy[rm] < key) begin
            lo = rm + 1;
         end else begin
            lo = lm + 1;
            hi = rm;
         end
      end
      return res;
   endfunction

   task automatic plan_store(input int unsigned idx, input logic signed [ENTRY_W-1:0] value);
      table_op_type op;
      op.command     = CMD_WRITE;
      op.entry_index = idx[IDX_W-1:0];
      op.entry_value = value;
      op.search_key  = ENTRY_W'($urandom);
      plan_entries[idx] = value;
      pending_beats.push_back(op);
      beats_planned++;
   endtask

   task automatic plan_lookup(input logic signed [ENTRY_W-1:0] key);
      table_op_type op;
      op.command     = CMD_SEARCH;
      op.entry_index = IDX_W'($urandom);
      op.entry_value = ENTRY_W'($urandom);
      op.search_key  = key;
      pending_beats.push_back(op);
      beats_planned++;
   endtask

   // hold until every planned beat is taken and answered, then let the block settle
   task automatic wait_drained();
      @(posedge clock);
      while (beats_accepted != beats_planned || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_entry_count(input int unsigned value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value[CFG_W-1:0];
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      entry_count = value[CFG_W-1:0];
      csr_valid <= 1'b0;
   endtask

   // request driver: offer queued beats, update the predictor on each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req_valid && req_chan.ready) begin
            if (req_beat.command == CMD_WRITE) begin
               table_copy[req_beat.entry_index] = req_beat.entry_value;
            end else begin
               expected_results.push_back(ternary_lookup(req_beat.search_key));
            end
            beats_accepted++;
         end
         if (!req_valid || req_chan.ready) begin
            if (req_gap != 0) begin
               req_gap   <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
               req_beat  <= pending_beats.pop_front();
               req_valid <= 1'b1;
               req_gap   <= idle_length();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: compare each beat with the oldest outstanding lookup
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_chan.valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result beat: found=%0b position=%0d",
                           rsp_chan.found, rsp_chan.position);
            end else begin
               want = expected_results.pop_front();
               if (rsp_chan.found !== want.found || rsp_chan.position !== want.position) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"result mismatch: expected found=%0b position=%0d,",
                               " got found=%0b position=%0d"},
                              want.found, want.position, rsp_chan.found, rsp_chan.position);
               end
            end
         end
         // back-pressure: forced hold, then random stalls
         if (rsp_hold) begin
            rsp_ready <= 1'b0;
         end else if (rsp_stall != 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(3, 0) == 0) begin
            rsp_stall <= idle_length();
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // long receiver hold while the sender keeps offering, so the input backs up
   initial begin
      wait (phase_no == 1);
      repeat (150) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (700) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int unsigned               span_n, idx, r, t, j;
      longint                    lo_v, hi_v;
      logic signed [ENTRY_W-1:0] key;
      int unsigned               load_order [TABLE_DEPTH];
      logic signed [ENTRY_W-1:0] load_value [TABLE_DEPTH];
      int unsigned               phase_counts [PHASES];

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty range: lookups must miss without touching storage
      write_entry_count(0);
      plan_lookup(0);
      plan_lookup(KEY_MIN);

      // short sorted run with both value extremes, plus the top slot
      plan_store(0, KEY_MIN);
      plan_store(1, -7);
      plan_store(2, 0);
      plan_store(3, 100);
      plan_store(4, KEY_MAX);
      plan_store(TABLE_DEPTH - 1, KEY_MAX);

      write_entry_count(1);
      plan_lookup(KEY_MIN);
      plan_lookup(KEY_MAX);

      write_entry_count(5);
      plan_lookup(KEY_MIN);
      plan_lookup(-7);
      plan_lookup(0);
      plan_lookup(100);
      plan_lookup(KEY_MAX);
      plan_lookup(50);

      // break the ordering and probe around the bad entry
      plan_store(2, 1000);
      plan_lookup(100);
      plan_lookup(1000);
      plan_lookup(0);

      // build an ascending table over the full value range, some duplicates
      for (idx = 0; idx < TABLE_DEPTH; idx++) begin
         load_order[idx] = idx;
         load_value[idx] = 32'(longint'(KEY_MIN) + longint'(idx) * 4194304
                               + longint'($urandom_range(4194303, 0)));
         if (idx != 0 && $urandom_range(9, 0) == 0) load_value[idx] = load_value[idx - 1];
      end
      load_value[0]               = KEY_MIN;
      load_value[TABLE_DEPTH - 1] = KEY_MAX;

      // load it in shuffled order
      for (idx = TABLE_DEPTH - 1; idx > 0; idx--) begin
         j = $urandom_range(idx, 0);
         t = load_order[idx];
         load_order[idx] = load_order[j];
         load_order[j]   = t;
      end
      for (idx = 0; idx < TABLE_DEPTH; idx++) begin
         plan_store(load_order[idx], load_value[load_order[idx]]);
         // slip in a lookup over the five-entry window or a random key now and then
         r = $urandom_range(19, 0);
         if (r == 0) plan_lookup(plan_entries[$urandom_range(4, 0)]);
         else if (r == 1) plan_lookup($urandom);
      end

      // random phases over a spread of counts, saturated ones included
      phase_counts = '{TABLE_DEPTH, 2047, 1, 2, 3, 1025, 0, 0, 0, TABLE_DEPTH};
      for (j = 6; j < 9; j++) phase_counts[j] = $urandom_range(TABLE_DEPTH - 1, 4);

      for (int p = 0; p < PHASES; p++) begin
         write_entry_count(phase_counts[p]);
         phase_no = p;
         idle_on  = (p % 3 != 1);
         span_n   = (phase_counts[p] > TABLE_DEPTH) ? TABLE_DEPTH : phase_counts[p];
         for (int n = 0; n < PHASE_BEATS; n++) begin
            r   = $urandom_range(99, 0);
            idx = $urandom_range(TABLE_DEPTH - 1, 0);
            if (r < 15) begin
               // order-preserving update: stay between the neighbors
               if (idx == 0) lo_v = longint'(KEY_MIN);
               else lo_v = longint'(plan_entries[idx - 1]);
               if (idx == TABLE_DEPTH - 1) hi_v = longint'(KEY_MAX);
               else hi_v = longint'(plan_entries[idx + 1]);
               if (hi_v < lo_v) hi_v = lo_v;
               plan_store(idx, 32'(lo_v + longint'($urandom_range(32'(hi_v - lo_v), 0))));
            end else if (r < 19) begin
               plan_store(idx, $urandom);
            end else begin
               idx = $urandom_range(span_n - 1, 0);
               r   = $urandom_range(99, 0);
               if (r < 50) key = plan_entries[idx];
               else if (r < 70) key = plan_entries[idx] + ((r % 2 == 0) ? 1 : -1);
               else if (r < 85) key = $urandom;
               else if (r < 95) key = (r % 2 == 0) ? KEY_MIN : KEY_MAX;
               else key = plan_entries[$urandom_range(TABLE_DEPTH - 1, 0)];
               plan_lookup(key);
            end
         end
      end

      wait_drained();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
